// ----- rtl/core/b64enc_pkg.sv -----
`default_nettype none

package b64enc_pkg;

   // Depth of the job queue between front and back
   parameter int unsigned QUEUE_DEPTH = 4;

   // ASCII codes used by the alphabet map
   localparam logic [7:0] CHAR_PAD       = 8'd61;  // '='
   localparam logic [7:0] CHAR_PLUS      = 8'd43;  // '+'
   localparam logic [7:0] CHAR_SLASH     = 8'd47;  // '/'
   localparam logic [7:0] CHAR_MINUS     = 8'd45;  // '-'
   localparam logic [7:0] CHAR_UNDERLINE = 8'd95;  // '_'
   localparam logic [7:0] CHAR_UPPER_A   = 8'd65;  // 'A'
   localparam logic [7:0] CHAR_LOWER_OFS = 8'd71;  // 'a' minus 26
   localparam logic [7:0] CHAR_DIGIT_OFS = 8'd4;   // 52 minus '0'

   // Sextet range limits
   localparam logic [5:0] SEXT_LOWER  = 6'd26;
   localparam logic [5:0] SEXT_DIGIT  = 6'd52;
   localparam logic [5:0] SEXT_SYM62  = 6'd62;

   // Position of the next byte within its 3-byte group
   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'd0,
      PHASE_SECOND = 2'd1,
      PHASE_THIRD  = 2'd2
   } phase_type;

   // One classified byte: up to four output symbols
   typedef struct packed {
      logic [3:0]      pad;        // slot is '=' padding
      logic [3:0][5:0] sext;       // sextet per slot
      logic [1:0]      last_slot;  // index of final slot of this job
      logic            last;       // job closes the message
   } job_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Map one sextet to its ASCII character
   function automatic logic [7:0] sextet_char(input logic [5:0] s, input logic url);
      logic [7:0] c;
      if (s < SEXT_LOWER) begin
         c = CHAR_UPPER_A + {2'b00, s};
      end else if (s < SEXT_DIGIT) begin
         c = CHAR_LOWER_OFS + {2'b00, s};
      end else if (s < SEXT_SYM62) begin
         c = {2'b00, s} - CHAR_DIGIT_OFS;
      end else if (s == SEXT_SYM62) begin
         c = url ? CHAR_MINUS : CHAR_PLUS;
      end else begin
         c = url ? CHAR_UNDERLINE : CHAR_SLASH;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/b64enc_front.sv -----
`default_nettype none

module b64enc_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [7:0]                  req_data_byte,
   input  wire logic                        req_last_byte,
   input  wire b64enc_pkg::queue_status_type q_status,
   output logic                             req_stall,
   output logic                             push,
   output b64enc_pkg::job_type              push_job
);

   b64enc_pkg::phase_type phase_ff, phase_in;
   logic [3:0]            left_ff, left_in;
   logic                  accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign push      = accept;

   // Group position and leftover bits
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= b64enc_pkg::PHASE_FIRST;
         left_ff  <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

   // Classify the byte into output slots
   always_comb begin
      push_job      = '0;
      push_job.last = req_last_byte;
      phase_in      = phase_ff;
      left_in       = left_ff;
      case (phase_ff)
         b64enc_pkg::PHASE_SECOND: begin
            push_job.sext[0] = {left_ff[1:0], req_data_byte[7:4]};
            if (req_last_byte) begin
               push_job.sext[1]   = {req_data_byte[3:0], 2'b00};
               push_job.pad[2]    = 1'b1;
               push_job.last_slot = 2'd2;
            end else begin
               push_job.last_slot = 2'd0;
               left_in            = req_data_byte[3:0];
               phase_in           = b64enc_pkg::PHASE_THIRD;
            end
         end
         b64enc_pkg::PHASE_THIRD: begin
            push_job.sext[0]   = {left_ff, req_data_byte[7:6]};
            push_job.sext[1]   = req_data_byte[5:0];
            push_job.last_slot = 2'd1;
            left_in            = 4'd0;
            phase_in           = b64enc_pkg::PHASE_FIRST;
         end
         default: begin
            // start of group; the unused code acts the same
            push_job.sext[0] = req_data_byte[7:2];
            if (req_last_byte) begin
               push_job.sext[1]   = {req_data_byte[1:0], 4'b0000};
               push_job.pad[2]    = 1'b1;
               push_job.pad[3]    = 1'b1;
               push_job.last_slot = 2'd3;
            end else begin
               push_job.last_slot = 2'd0;
               left_in            = {2'b00, req_data_byte[1:0]};
               phase_in           = b64enc_pkg::PHASE_SECOND;
            end
         end
      endcase
      // message end restarts the group
      if (req_last_byte) begin
         phase_in = b64enc_pkg::PHASE_FIRST;
         left_in  = 4'd0;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/b64enc_fifo.sv -----
`default_nettype none

module b64enc_fifo #(
   parameter int unsigned DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire b64enc_pkg::job_type         push_job,
   input  wire logic                        pop,
   output b64enc_pkg::job_type              head_job,
   output b64enc_pkg::queue_status_type     q_status
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   b64enc_pkg::job_type mem_ff [DEPTH];
   logic [AW-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]       count_ff;
   logic                do_push, do_pop;

   assign q_status.full  = (count_ff == CW'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_job       = mem_ff[rd_ptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/b64enc_back.sv -----
`default_nettype none

module b64enc_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        url_alphabet,
   input  wire b64enc_pkg::job_type         head_job,
   input  wire b64enc_pkg::queue_status_type q_status,
   output logic                             pop,
   input  wire logic                        rsp_stall,
   output logic                             rsp_valid,
   output logic [7:0]                       rsp_out_char,
   output logic                             rsp_out_last
);

   logic [1:0] slot_ff;
   logic       valid_ff;
   logic [7:0] char_ff;
   logic       last_ff;
   logic       load;
   logic       slot_end;

   assign load      = !q_status.empty && (!valid_ff || !rsp_stall);
   assign slot_end  = (slot_ff == head_job.last_slot);
   assign pop       = load && slot_end;

   assign rsp_valid    = valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_out_last = last_ff;

   // Slot counter and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else if (load) begin
         slot_ff  <= slot_end ? 2'd0 : slot_ff + 2'd1;
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   // Output character register
   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= head_job.pad[slot_ff] ? b64enc_pkg::CHAR_PAD :
                    b64enc_pkg::sextet_char(head_job.sext[slot_ff], url_alphabet);
         last_ff <= head_job.last && slot_end;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/base64_stream_encoder.sv -----
`default_nettype none

// Base64 encoder (RFC 4648) for a byte stream. Each accepted byte on req_ is
// turned into the characters it completes and queued; rsp_ delivers one
// character per cycle while rsp_stall is low, with '=' padding after the final
// byte and rsp_out_last on the final character. Bytes are taken one per cycle
// while the job queue (QUEUE_DEPTH entries) has room; sustained, the
// single-character output register sets the rate, as the three bytes of a
// group yield one, one and two characters and a final byte up to four.
// csr_url_alphabet selects '-' and '_' instead of '+' and '/'; write it only
// while no message is in flight. csr_ready is always high.
module base64_stream_encoder #(
   parameter int unsigned QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_out_last,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_url_alphabet
);

   logic                         url_ff;
   logic                         push, pop;
   b64enc_pkg::job_type          push_job, head_job;
   b64enc_pkg::queue_status_type q_status;

   assign csr_ready = 1'b1;

   // Alphabet select register
   always_ff @(posedge clock) begin
      if (reset) begin
         url_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         url_ff <= csr_url_alphabet;
      end
   end

   b64enc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_status      (q_status),
      .req_stall     (req_stall),
      .push          (push),
      .push_job      (push_job)
   );

   b64enc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   b64enc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .url_alphabet (url_ff),
      .head_job     (head_job),
      .q_status     (q_status),
      .pop          (pop),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_out_char (rsp_out_char),
      .rsp_out_last (rsp_out_last)
   );

endmodule

`default_nettype wire

// ----- rtl/core/b64enc_checker.sv -----
`default_nettype none

module b64enc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_char,
   input wire logic       rsp_out_last
);

   // A stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_char) && $stable(rsp_out_last))
      else $error("result payload changed while stalled");

   // Nothing is offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // Every character is from the alphabets or padding
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_out_char >= 8'd65 && rsp_out_char <= 8'd90) ||
         (rsp_out_char >= 8'd97 && rsp_out_char <= 8'd122) ||
         (rsp_out_char >= 8'd48 && rsp_out_char <= 8'd57) ||
         rsp_out_char == 8'd43 || rsp_out_char == 8'd47 ||
         rsp_out_char == 8'd45 || rsp_out_char == 8'd95 ||
         rsp_out_char == 8'd61)
      else $error("character outside Base64 alphabet");

endmodule

bind base64_stream_encoder b64enc_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_char (rsp_out_char),
   .rsp_out_last (rsp_out_last)
);

`default_nettype wire
